FILE: design/tgr_pkg.sv
// Shared types, codes and constants of the touch gesture recogniser.
`default_nettype none

package tgr_pkg;

   // Event kinds carried on the request tuser
   localparam logic [2:0] MODE_DOWN   = 3'd0;
   localparam logic [2:0] MODE_MOTION = 3'd1;
   localparam logic [2:0] MODE_UP     = 3'd2;
   localparam logic [2:0] MODE_CANCEL = 3'd3;
   localparam logic [2:0] MODE_TICK   = 3'd4;

   // Gesture codes carried on the response tuser
   localparam logic [2:0] GEST_NONE       = 3'd0;
   localparam logic [2:0] GEST_PRESS      = 3'd1;
   localparam logic [2:0] GEST_MOVE       = 3'd2;
   localparam logic [2:0] GEST_RELEASE    = 3'd3;
   localparam logic [2:0] GEST_SWIPE_UP   = 3'd4;
   localparam logic [2:0] GEST_SWIPE_DOWN = 3'd5;
   localparam logic [2:0] GEST_LONG_PRESS = 3'd6;
   localparam logic [2:0] GEST_CANCEL     = 3'd7;

   // Configuration register indexes
   localparam logic [1:0] REG_LONG_PRESS = 2'd0;
   localparam logic [1:0] REG_SLOP       = 2'd1;
   localparam logic [1:0] REG_SWIPE      = 2'd2;
   localparam logic [1:0] REG_STALE      = 2'd3;

   // Register reset values; all but the slop value also stand in for a zero setting
   localparam logic [15:0] DEF_LONG_PRESS = 16'd500;
   localparam logic [15:0] DEF_SLOP       = 16'd128;
   localparam logic [15:0] DEF_SWIPE      = 16'd640;
   localparam logic [15:0] DEF_STALE      = 16'd5000;

   typedef struct packed {
      logic [15:0] long_press_ms;
      logic [15:0] slop_dist;
      logic [15:0] swipe_dist;
      logic [15:0] stale_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic [15:0]        finger_id;
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
      logic [31:0]        time_ms;
      logic               over_chrome;
      logic               roll_target;
   } req_item_type;

   typedef struct packed {
      logic [2:0]         gesture;
      logic signed [19:0] out_x;
      logic signed [19:0] out_y;
      logic               consumed;
      logic               due_valid;
      logic [31:0]        due_time;
   } rsp_item_type;

   // Sequence state held between items
   typedef struct packed {
      logic               active;
      logic [15:0]        id;
      logic signed [19:0] org_x;
      logic signed [19:0] org_y;
      logic signed [19:0] last_x;
      logic signed [19:0] last_y;
      logic               sec_active;
      logic [15:0]        sec_id;
      logic signed [19:0] sec_org_y;
      logic [31:0]        press_time;
      logic [31:0]        last_time;
      logic               armed;
      logic               roll;
      logic               moved;
      logic               finished;
      logic               lifted;
   } state_type;

   // Distance checks handed from the motion unit to the sequencer
   typedef struct packed {
      logic beyond_slop;
      logic swipe_hit;
      logic swipe_up;
   } motion_type;

endpackage

`default_nettype wire

FILE: design/touch_gesture_recognizer_core.sv
// Top level of the touch gesture recogniser: stream ports, registers and item staging.
// Takes one touch item per clock while rsp_tready stays high and returns exactly one
// result item for each, in order. An accepted item sits in the input register, is
// resolved in a single pass of the sequence logic (flag update, squared-distance slop
// check, swipe travel compare) and lands in the output register, which drives
// rsp_tvalid. A stalled result holds in the output register while the next item waits
// in the input register. Configuration writes are taken in any cycle and should be
// made only while no item is in flight.
`default_nettype none

module touch_gesture_recognizer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // finger_id[15:0], pos_x[35:16], pos_y[55:36], time_ms[87:56],
   // over_chrome[88], roll_target[89], zero[95:90]
   input  wire logic [95:0] req_tdata,
   // mode[2:0]
   input  wire logic [2:0]  req_tuser,
   // Response stream
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_x[19:0], out_y[39:20], consumed[40], due_valid[41], due_time[73:42],
   // zero[79:74]
   output      logic [79:0] rsp_tdata,
   // gesture[2:0]
   output      logic [2:0]  rsp_tuser,
   // Register write port
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   tgr_pkg::req_item_type req_item;
   tgr_pkg::req_item_type in_item_ff;
   tgr_pkg::rsp_item_type result;
   tgr_pkg::rsp_item_type rsp_item_ff;
   tgr_pkg::cfg_type      cfg_ff;
   tgr_pkg::cfg_type      cfg_in;

   logic in_valid_ff;
   logic in_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic advance;
   logic req_fire;

   // Unpack the request item
   assign req_item.mode        = req_tuser;
   assign req_item.finger_id   = req_tdata[15:0];
   assign req_item.pos_x       = req_tdata[35:16];
   assign req_item.pos_y       = req_tdata[55:36];
   assign req_item.time_ms     = req_tdata[87:56];
   assign req_item.over_chrome = req_tdata[88];
   assign req_item.roll_target = req_tdata[89];

   // Process the staged item whenever the output register can take its result
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   tgr_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // Register writes
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tgr_pkg::REG_LONG_PRESS: cfg_in.long_press_ms = csr_data;
            tgr_pkg::REG_SLOP:       cfg_in.slop_dist     = csr_data;
            tgr_pkg::REG_SWIPE:      cfg_in.swipe_dist    = csr_data;
            tgr_pkg::REG_STALE:      cfg_in.stale_ms      = csr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         cfg_ff.long_press_ms <= tgr_pkg::DEF_LONG_PRESS;
         cfg_ff.slop_dist     <= tgr_pkg::DEF_SLOP;
         cfg_ff.swipe_dist    <= tgr_pkg::DEF_SWIPE;
         cfg_ff.stale_ms      <= tgr_pkg::DEF_STALE;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   // Pack the response item
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.gesture;
   assign rsp_tdata  = {6'd0, rsp_item_ff.due_time, rsp_item_ff.due_valid,
                        rsp_item_ff.consumed, rsp_item_ff.out_y, rsp_item_ff.out_x};

endmodule

`default_nettype wire

FILE: design/tgr_motion.sv
// Squared slop distance and vertical swipe travel checks for a motion item.
`default_nettype none

module tgr_motion (
   input  wire logic signed [19:0] pos_x,
   input  wire logic signed [19:0] pos_y,
   input  wire logic signed [19:0] org_x,
   input  wire logic signed [19:0] org_y,
   input  wire logic signed [19:0] sec_org_y,
   input  wire logic               use_primary,
   input  wire logic [15:0]        slop_dist,
   input  wire logic [15:0]        swipe_eff,
   output tgr_pkg::motion_type     motion
);

   logic signed [20:0] dx;
   logic signed [20:0] dy;
   logic signed [41:0] sq_x;
   logic signed [41:0] sq_y;
   logic [42:0]        d2;
   logic [31:0]        s2;
   logic signed [19:0] swipe_org;
   logic signed [20:0] sdy;
   logic [20:0]        ady;

   // Squared distance from the primary origin against squared slop
   assign dx   = {pos_x[19], pos_x} - {org_x[19], org_x};
   assign dy   = {pos_y[19], pos_y} - {org_y[19], org_y};
   assign sq_x = 42'(dx) * 42'(dx);
   assign sq_y = 42'(dy) * 42'(dy);
   assign d2   = {1'b0, sq_x} + {1'b0, sq_y};
   assign s2   = 32'(slop_dist) * 32'(slop_dist);

   // Vertical travel from the origin of whichever finger moved
   assign swipe_org = use_primary ? org_y : sec_org_y;
   assign sdy       = {pos_y[19], pos_y} - {swipe_org[19], swipe_org};
   assign ady       = sdy[20] ? 21'(-sdy) : 21'(sdy);

   assign motion.beyond_slop = d2 > {11'd0, s2};
   assign motion.swipe_hit   = ady >= {5'd0, swipe_eff};
   assign motion.swipe_up    = sdy[20];

endmodule

`default_nettype wire

FILE: design/tgr_seq.sv
// Sequence state and the single-pass update that forms one result per item.
`default_nettype none

module tgr_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire tgr_pkg::req_item_type item,
   input  wire tgr_pkg::cfg_type      cfg,
   output tgr_pkg::rsp_item_type      result
);

   tgr_pkg::state_type  st_ff;
   tgr_pkg::state_type  st_in;
   tgr_pkg::motion_type motion;

   logic [15:0] long_eff;
   logic [15:0] swipe_eff;
   logic [15:0] stale_eff;
   logic        stale;
   logic        hit_primary;
   logic        hit_second;
   logic        long_due;

   // Zero settings fall back to the defaults, slop excepted
   assign long_eff  = (cfg.long_press_ms == 16'd0) ? tgr_pkg::DEF_LONG_PRESS : cfg.long_press_ms;
   assign swipe_eff = (cfg.swipe_dist == 16'd0) ? tgr_pkg::DEF_SWIPE : cfg.swipe_dist;
   assign stale_eff = (cfg.stale_ms == 16'd0) ? tgr_pkg::DEF_STALE : cfg.stale_ms;

   assign stale = st_ff.active &&
                  ((item.time_ms - st_ff.last_time) >= {16'd0, stale_eff});
   assign hit_primary = (item.finger_id == st_ff.id) && !st_ff.lifted;
   assign hit_second  = st_ff.sec_active && (item.finger_id == st_ff.sec_id);
   assign long_due    = st_ff.active && st_ff.armed && !st_ff.moved && !st_ff.finished &&
                        ((item.time_ms - st_ff.press_time) >= {16'd0, long_eff});

   tgr_motion u_motion (
      .pos_x       (item.pos_x),
      .pos_y       (item.pos_y),
      .org_x       (st_ff.org_x),
      .org_y       (st_ff.org_y),
      .sec_org_y   (st_ff.sec_org_y),
      .use_primary (hit_primary),
      .slop_dist   (cfg.slop_dist),
      .swipe_eff   (swipe_eff),
      .motion      (motion)
   );

   // Drop the whole sequence; payload fields are dead once inactive
   function automatic tgr_pkg::state_type clear_seq(input tgr_pkg::state_type s);
      tgr_pkg::state_type r;
      r            = s;
      r.active     = 1'b0;
      r.sec_active = 1'b0;
      r.armed      = 1'b0;
      r.roll       = 1'b0;
      r.moved      = 1'b0;
      r.finished   = 1'b0;
      r.lifted     = 1'b0;
      return r;
   endfunction

   // Work out the next state and the result of the item
   always_comb begin
      st_in            = st_ff;
      result.gesture   = tgr_pkg::GEST_NONE;
      result.out_x     = '0;
      result.out_y     = '0;
      result.consumed  = 1'b0;
      case (item.mode)
         tgr_pkg::MODE_DOWN: begin
            result.out_x = item.pos_x;
            result.out_y = item.pos_y;
            if (st_ff.active && !stale) begin
               if (item.finger_id == st_ff.id) begin
                  st_in.last_time = item.time_ms;
                  result.consumed = 1'b1;
               end else if (item.over_chrome) begin
                  st_in.last_time = item.time_ms;
                  if (!st_ff.sec_active && !st_ff.finished && !st_ff.moved &&
                      st_ff.roll && !st_ff.lifted) begin
                     st_in.sec_active = 1'b1;
                     st_in.sec_id     = item.finger_id;
                     st_in.sec_org_y  = item.pos_y;
                  end
                  st_in.finished  = st_ff.finished || !st_ff.roll || st_ff.moved;
                  st_in.armed     = 1'b0;
                  result.consumed = 1'b1;
               end
            end else if (item.over_chrome) begin
               st_in.active     = 1'b1;
               st_in.id         = item.finger_id;
               st_in.org_x      = item.pos_x;
               st_in.last_x     = item.pos_x;
               st_in.org_y      = item.pos_y;
               st_in.last_y     = item.pos_y;
               st_in.sec_active = 1'b0;
               st_in.press_time = item.time_ms;
               st_in.last_time  = item.time_ms;
               st_in.armed      = 1'b1;
               st_in.roll       = item.roll_target;
               st_in.moved      = 1'b0;
               st_in.finished   = 1'b0;
               st_in.lifted     = 1'b0;
               result.gesture   = tgr_pkg::GEST_PRESS;
               result.consumed  = 1'b1;
            end else if (stale) begin
               st_in = clear_seq(st_ff);
            end
         end
         tgr_pkg::MODE_MOTION: begin
            result.out_x = item.pos_x;
            result.out_y = item.pos_y;
            if (st_ff.active && (hit_primary || hit_second)) begin
               st_in.last_time = item.time_ms;
               result.consumed = 1'b1;
               if (hit_primary) begin
                  st_in.last_x = item.pos_x;
                  st_in.last_y = item.pos_y;
               end
               if (st_ff.finished) begin
                  result.gesture = tgr_pkg::GEST_NONE;
               end else if (st_ff.sec_active) begin
                  if (motion.swipe_hit) begin
                     st_in.finished = 1'b1;
                     st_in.armed    = 1'b0;
                     result.gesture = motion.swipe_up ? tgr_pkg::GEST_SWIPE_UP
                                                      : tgr_pkg::GEST_SWIPE_DOWN;
                  end
               end else begin
                  if (!st_ff.moved && motion.beyond_slop) begin
                     st_in.moved = 1'b1;
                     st_in.armed = 1'b0;
                  end
                  result.gesture = tgr_pkg::GEST_MOVE;
               end
            end
         end
         tgr_pkg::MODE_UP: begin
            if (st_ff.active) begin
               if (hit_second) begin
                  st_in.last_time  = item.time_ms;
                  st_in.sec_active = 1'b0;
                  st_in.finished   = 1'b1;
                  if (st_ff.lifted) begin
                     st_in = clear_seq(st_ff);
                  end
                  result.consumed = 1'b1;
               end else if (hit_primary) begin
                  st_in.last_time = item.time_ms;
                  result.consumed = 1'b1;
                  if (st_ff.sec_active) begin
                     st_in.finished = 1'b1;
                     st_in.armed    = 1'b0;
                     st_in.lifted   = 1'b1;
                  end else begin
                     result.out_x   = st_ff.last_x;
                     result.out_y   = st_ff.last_y;
                     st_in          = clear_seq(st_ff);
                     result.gesture = st_ff.finished ? tgr_pkg::GEST_NONE
                                                     : tgr_pkg::GEST_RELEASE;
                  end
               end
            end
         end
         tgr_pkg::MODE_CANCEL: begin
            result.consumed = st_ff.active;
            st_in           = clear_seq(st_ff);
            result.gesture  = tgr_pkg::GEST_CANCEL;
         end
         tgr_pkg::MODE_TICK: begin
            if (long_due) begin
               st_in.armed     = 1'b0;
               st_in.finished  = 1'b1;
               result.gesture  = tgr_pkg::GEST_LONG_PRESS;
               result.out_x    = st_ff.last_x;
               result.out_y    = st_ff.last_y;
               result.consumed = 1'b1;
            end
         end
         default: begin
            st_in = st_ff;
         end
      endcase
      // Long press deadline as it stands after the item
      result.due_valid = st_in.active && st_in.armed;
      result.due_time  = result.due_valid ? (st_in.press_time + {16'd0, long_eff}) : 32'd0;
   end

   // Hold the sequence state; advance it once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/tgr_checker.sv
// Port-level checks on the touch gesture recogniser, bound to its top level.
`default_nettype none

module tgr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [79:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // An empty output side never back-pressures the request side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   // Once an accepted item has passed through the input register, the output side is valid
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> ##1 rsp_tvalid)
      else $error("accepted item gave no result");

   // Cancel and release end the sequence, so no long press stays due
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tgr_pkg::GEST_CANCEL || rsp_tuser == tgr_pkg::GEST_RELEASE)
      |-> !rsp_tdata[41] && rsp_tdata[73:42] == 32'd0)
      else $error("deadline pending after sequence end");

endmodule

bind touch_gesture_recognizer_core tgr_checker u_tgr_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench of the touch gesture recogniser core.
`timescale 1ns / 100ps

module testbench;

   localparam int PHASE_ITEMS = 258;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_AT     = 600;
   localparam int HOLD_CYCLES = 300;

   // Scoreboard: gesture predictor plus the queue of results still owed by the core
   class gesture_book;
      logic [15:0] hold_reg, slop_reg, swipe_reg, stale_reg;
      logic active, sec_active, armed, roll_ok, moved, finished, lifted;
      logic [15:0] prim_id, sec_id;
      logic signed [19:0] org_x, org_y, last_x, last_y, sec_org_y;
      logic [31:0] press_time, last_time;
      tgr_pkg::rsp_item_type owed_q[$];
      int mismatches;
      int results;

      function new();
         clear_seq();
         hold_reg   = tgr_pkg::DEF_LONG_PRESS;
         slop_reg   = tgr_pkg::DEF_SLOP;
         swipe_reg  = tgr_pkg::DEF_SWIPE;
         stale_reg  = tgr_pkg::DEF_STALE;
         mismatches = 0;
         results    = 0;
      endfunction

      function void clear_seq();
         active = 1'b0; sec_active = 1'b0; armed = 1'b0; roll_ok = 1'b0;
         moved = 1'b0; finished = 1'b0; lifted = 1'b0;
         prim_id = '0; sec_id = '0;
         org_x = '0; org_y = '0; last_x = '0; last_y = '0; sec_org_y = '0;
         press_time = '0; last_time = '0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            tgr_pkg::REG_LONG_PRESS: hold_reg  = val;
            tgr_pkg::REG_SLOP:       slop_reg  = val;
            tgr_pkg::REG_SWIPE:      swipe_reg = val;
            tgr_pkg::REG_STALE:      stale_reg = val;
            default: ;
         endcase
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // Work out the one result an event causes and advance the sequence state
      function tgr_pkg::rsp_item_type recognise(tgr_pkg::req_item_type ev);
         tgr_pkg::rsp_item_type r;
         logic [31:0] hold_ms, swipe_lim, stale_lim;
         logic signed [19:0] ref_y;
         logic own_prim, own_sec, fin;
         int dy, ady;
         longint ddx, ddy;
         hold_ms   = (hold_reg != 0)  ? 32'(hold_reg)  : 32'(tgr_pkg::DEF_LONG_PRESS);
         swipe_lim = (swipe_reg != 0) ? 32'(swipe_reg) : 32'(tgr_pkg::DEF_SWIPE);
         stale_lim = (stale_reg != 0) ? 32'(stale_reg) : 32'(tgr_pkg::DEF_STALE);
         r = '0;
         case (ev.mode)
            tgr_pkg::MODE_DOWN: begin
               // drop a sequence that has sat idle too long
               if (active && (ev.time_ms - last_time) >= stale_lim) clear_seq();
               r.out_x = ev.pos_x;
               r.out_y = ev.pos_y;
               if (active) begin
                  if (ev.finger_id == prim_id) begin
                     last_time  = ev.time_ms;
                     r.consumed = 1'b1;
                  end else if (ev.over_chrome) begin
                     last_time = ev.time_ms;
                     if (!sec_active && !finished && !moved && roll_ok && !lifted) begin
                        sec_active = 1'b1;
                        sec_id     = ev.finger_id;
                        sec_org_y  = ev.pos_y;
                     end
                     finished   = finished || !roll_ok || moved;
                     armed      = 1'b0;
                     r.consumed = 1'b1;
                  end
               end else if (ev.over_chrome) begin
                  active = 1'b1; prim_id = ev.finger_id;
                  org_x = ev.pos_x; last_x = ev.pos_x;
                  org_y = ev.pos_y; last_y = ev.pos_y;
                  sec_active = 1'b0;
                  press_time = ev.time_ms; last_time = ev.time_ms;
                  armed = 1'b1; roll_ok = ev.roll_target;
                  moved = 1'b0; finished = 1'b0; lifted = 1'b0;
                  r.gesture  = tgr_pkg::GEST_PRESS;
                  r.consumed = 1'b1;
               end
            end
            tgr_pkg::MODE_MOTION: begin
               r.out_x  = ev.pos_x;
               r.out_y  = ev.pos_y;
               own_prim = active && ev.finger_id == prim_id && !lifted;
               own_sec  = active && !own_prim && sec_active && ev.finger_id == sec_id;
               if (own_prim || own_sec) begin
                  last_time  = ev.time_ms;
                  r.consumed = 1'b1;
                  if (own_prim) begin
                     last_x = ev.pos_x;
                     last_y = ev.pos_y;
                  end
                  if (finished) begin
                     r.gesture = tgr_pkg::GEST_NONE;
                  end else if (sec_active) begin
                     // two fingers down: only vertical travel counts
                     ref_y = own_prim ? org_y : sec_org_y;
                     dy    = int'($signed(ev.pos_y)) - int'(ref_y);
                     ady   = (dy < 0) ? -dy : dy;
                     if (ady >= int'(swipe_lim)) begin
                        finished  = 1'b1;
                        armed     = 1'b0;
                        r.gesture = (dy < 0) ? tgr_pkg::GEST_SWIPE_UP
                                             : tgr_pkg::GEST_SWIPE_DOWN;
                     end
                  end else begin
                     if (!moved) begin
                        ddx = longint'($signed(ev.pos_x)) - longint'(org_x);
                        ddy = longint'($signed(ev.pos_y)) - longint'(org_y);
                        if (ddx * ddx + ddy * ddy >
                            longint'(slop_reg) * longint'(slop_reg)) begin
                           moved = 1'b1;
                           armed = 1'b0;
                        end
                     end
                     r.gesture = tgr_pkg::GEST_MOVE;
                  end
               end
            end
            tgr_pkg::MODE_UP: begin
               if (active) begin
                  if (sec_active && ev.finger_id == sec_id) begin
                     last_time  = ev.time_ms;
                     sec_active = 1'b0;
                     finished   = 1'b1;
                     if (lifted) clear_seq();
                     r.consumed = 1'b1;
                  end else if (ev.finger_id == prim_id && !lifted) begin
                     last_time  = ev.time_ms;
                     r.consumed = 1'b1;
                     if (sec_active) begin
                        finished = 1'b1;
                        armed    = 1'b0;
                        lifted   = 1'b1;
                     end else begin
                        // final lift of a lone primary reports where it was
                        fin       = finished;
                        r.out_x   = last_x;
                        r.out_y   = last_y;
                        clear_seq();
                        r.gesture = fin ? tgr_pkg::GEST_NONE : tgr_pkg::GEST_RELEASE;
                     end
                  end
               end
            end
            tgr_pkg::MODE_CANCEL: begin
               r.consumed = active;
               clear_seq();
               r.gesture = tgr_pkg::GEST_CANCEL;
            end
            tgr_pkg::MODE_TICK: begin
               if (active && armed && !moved && !finished &&
                   (ev.time_ms - press_time) >= hold_ms) begin
                  armed      = 1'b0;
                  finished   = 1'b1;
                  r.gesture  = tgr_pkg::GEST_LONG_PRESS;
                  r.out_x    = last_x;
                  r.out_y    = last_y;
                  r.consumed = 1'b1;
               end
            end
            default: ;
         endcase
         if (active && armed) begin
            r.due_valid = 1'b1;
            r.due_time  = press_time + hold_ms;
         end
         return r;
      endfunction

      function void note(tgr_pkg::req_item_type ev);
         owed_q.push_back(recognise(ev));
      endfunction

      function void check(logic [2:0] gest, logic [79:0] d);
         tgr_pkg::rsp_item_type got, want;
         got.gesture   = gest;
         got.out_x     = d[19:0];
         got.out_y     = d[39:20];
         got.consumed  = d[40];
         got.due_valid = d[41];
         got.due_time  = d[73:42];
         results++;
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result %0d arrived with nothing owed, gesture %0d", results,
                        gest);
            return;
         end
         want = owed_q.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: result %0d (expected/actual) gesture %0d/%0d x %0d/%0d ",
                         "y %0d/%0d consumed %0b/%0b due %0b/%0b at %0h/%0h"},
                        results, want.gesture, got.gesture,
                        $signed(want.out_x), $signed(got.out_x),
                        $signed(want.out_y), $signed(got.out_y),
                        want.consumed, got.consumed, want.due_valid, got.due_valid,
                        want.due_time, got.due_time);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   gesture_book book = new();
   int          handshakes = 0;
   int          sent_items = 0;
   int          hold_left = 0;
   bit          held_once = 1'b0;
   bit          quiet_phase = 1'b0;
   int          hold_eff = 500;
   int          stale_eff = 5000;
   logic [31:0] now_ms = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   touch_gesture_recognizer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Observe every handshake at the edge, then pace the result side
   always @(posedge clock) begin : monitor
      tgr_pkg::req_item_type ev;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            ev.mode        = req_tuser;
            ev.finger_id   = req_tdata[15:0];
            ev.pos_x       = req_tdata[35:16];
            ev.pos_y       = req_tdata[55:36];
            ev.time_ms     = req_tdata[87:56];
            ev.over_chrome = req_tdata[88];
            ev.roll_target = req_tdata[89];
            book.note(ev);
            handshakes++;
         end
         if (rsp_tvalid && rsp_tready) begin
            book.check(rsp_tuser, rsp_tdata);
            handshakes++;
         end
         if (csr_valid && csr_ready) begin
            book.set_reg(csr_index, csr_data);
            handshakes++;
         end
         // hold off once for a long stretch so the core backs up
         if (!held_once && book.results >= HOLD_AT) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_phase || ($urandom_range(99) >= 26);
         end
      end
   end

   // End the run when nothing has moved for too long
   initial begin : watchdog
      int seen, still;
      seen  = 0;
      still = 0;
      while (still < STALL_LIMIT) begin
         @(posedge clock);
         if (handshakes != seen) begin
            seen  = handshakes;
            still = 0;
         end else begin
            still++;
         end
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int jitter(input int amp);
      return int'($urandom_range(2 * amp)) - amp;
   endfunction

   // Offer one touch event and hold it until the core takes it
   task automatic push_event(input logic [2:0] mode, input logic [15:0] id, input int x,
                             input int y, input logic [31:0] t, input logic chrome,
                             input logic roll);
      logic [19:0] xw, yw;
      xw = x[19:0];
      yw = y[19:0];
      if (!quiet_phase) begin
         while ($urandom_range(99) < 26) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'd0, roll, chrome, t, yw, xw, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (mode <= tgr_pkg::MODE_TICK) sent_items++;
   endtask

   // Drain the core, let it settle, then load all four registers
   task automatic configure(input logic [15:0] hold, input logic [15:0] slop,
                            input logic [15:0] swipe, input logic [15:0] stale);
      logic [15:0] vals [4];
      int k;
      vals[tgr_pkg::REG_LONG_PRESS] = hold;
      vals[tgr_pkg::REG_SLOP]       = slop;
      vals[tgr_pkg::REG_SWIPE]      = swipe;
      vals[tgr_pkg::REG_STALE]      = stale;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      for (k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= 2'(k);
         csr_data  <= vals[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      hold_eff  = (hold != 0) ? int'(hold) : int'(tgr_pkg::DEF_LONG_PRESS);
      stale_eff = (stale != 0) ? int'(stale) : int'(tgr_pkg::DEF_STALE);
   endtask

   // Hand-picked events: field extremes, every mode and the corner behaviours
   task automatic directed_run();
      logic [31:0] t0;
      // nothing open: cancel, tick, up, motion, a down off the decoration
      push_event(tgr_pkg::MODE_CANCEL, 16'd0, 0, 0, 32'd1000, 1'b0, 1'b0);
      push_event(tgr_pkg::MODE_TICK, 16'd0, 0, 0, 32'd1000, 1'b0, 1'b0);
      push_event(tgr_pkg::MODE_UP, 16'd1, 5, 5, 32'd1001, 1'b1, 1'b0);
      push_event(tgr_pkg::MODE_MOTION, 16'd1, 5, 5, 32'd1002, 1'b1, 1'b0);
      push_event(tgr_pkg::MODE_DOWN, 16'hFFFF, 100, 100, 32'd1003, 1'b0, 1'b1);
      // press at the corner, wobble within slop, then hold into a long press
      push_event(tgr_pkg::MODE_DOWN, 16'd5, -524288, 524287, 32'd1010, 1'b1, 1'b0);
      push_event(tgr_pkg::MODE_MOTION, 16'd5, -524280, 524279, 32'd1020, 1'b1, 1'b0);
      push_event(tgr_pkg::MODE_DOWN, 16'd8, 7, 7, 32'd1022, 1'b0, 1'b0);
      push_event(tgr_pkg::MODE_TICK, 16'd0, 0, 0, 32'd1509, 1'b0, 1'b0);
      push_event(tgr_pkg::MODE_TICK, 16'd0, 0, 0, 32'd1510, 1'b0, 1'b0);
      push_event(tgr_pkg::MODE_MOTION, 16'd5, -524200, 524200, 32'd1520, 1'b1, 1'b0);
      push_event(tgr_pkg::MODE_UP, 16'd5, 0, 0, 32'd1530, 1'b1, 1'b0);
      // two-finger swipe up by the second finger, primary lifts first
      push_event(tgr_pkg::MODE_DOWN, 16'hFFFF, 524287, -523288, 32'd2000, 1'b1, 1'b1);
      push_event(tgr_pkg::MODE_DOWN, 16'h0000, 524287, -523288, 32'd2005, 1'b1, 1'b1);
      push_event(tgr_pkg::MODE_MOTION, 16'h0000, 524287, -523927, 32'd2010, 1'b1, 1'b1);
      push_event(tgr_pkg::MODE_MOTION, 16'h0000, 524287, -523928, 32'd2015, 1'b1, 1'b1);
      push_event(tgr_pkg::MODE_UP, 16'hFFFF, 0, 0, 32'd2020, 1'b1, 1'b1);
      push_event(tgr_pkg::MODE_UP, 16'h0000, 0, 0, 32'd2025, 1'b1, 1'b1);
      // swipe down by the primary, then cancel an open sequence
      push_event(tgr_pkg::MODE_DOWN, 16'd9, 0, 0, 32'd3000, 1'b1, 1'b1);
      push_event(tgr_pkg::MODE_DOWN, 16'd10, 0, 0, 32'd3005, 1'b1, 1'b1);
      push_event(tgr_pkg::MODE_MOTION, 16'd9, 0, 640, 32'd3010, 1'b1, 1'b1);
      push_event(tgr_pkg::MODE_CANCEL, 16'd9, 0, 0, 32'd3015, 1'b0, 1'b0);
      // drag past slop and release
      push_event(tgr_pkg::MODE_DOWN, 16'd3, 0, 0, 32'd4000, 1'b1, 1'b0);
      push_event(tgr_pkg::MODE_MOTION, 16'd3, 100, 90, 32'd4010, 1'b1, 1'b0);
      push_event(tgr_pkg::MODE_UP, 16'd3, 0, 0, 32'd4020, 1'b1, 1'b0);
      // stale sequence across the time wrap, then unknown modes
      t0 = 32'hFFFF_FF00;
      push_event(tgr_pkg::MODE_DOWN, 16'd4, 0, 0, t0, 1'b1, 1'b0);
      push_event(tgr_pkg::MODE_TICK, 16'd0, 0, 0, t0 + 32'd10, 1'b0, 1'b0);
      push_event(tgr_pkg::MODE_DOWN, 16'd6, 16, 16, t0 + 32'd5000, 1'b1, 1'b0);
      push_event(3'd5, 16'd6, 1, 1, t0 + 32'd5001, 1'b1, 1'b1);
      push_event(3'd7, 16'd6, 1, 1, t0 + 32'd5002, 1'b1, 1'b1);
      push_event(tgr_pkg::MODE_CANCEL, 16'd6, 0, 0, t0 + 32'd5003, 1'b0, 1'b0);
   endtask

   // One plausible touch sequence with random content
   task automatic gesture_run();
      logic [15:0] p_id, s_id;
      logic [31:0] press_ms, tick_t;
      int ox, oy, sy, amp, n, k;
      bit two, roll, s_down;
      p_id     = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
      s_id     = p_id + 16'($urandom_range(3, 1));
      ox       = jitter(524287);
      oy       = jitter(524287);
      sy       = oy;
      roll     = $urandom_range(99) < 60;
      two      = roll && $urandom_range(99) < 55;
      s_down   = 1'b0;
      now_ms  += $urandom_range(60);
      press_ms = now_ms;
      push_event(tgr_pkg::MODE_DOWN, p_id, ox, oy, now_ms, $urandom_range(99) < 92, roll);
      n = $urandom_range(6);
      for (k = 0; k < n; k++) begin
         amp = 1 << $urandom_range(17, 2);
         if (two && !s_down && $urandom_range(2) == 0) begin
            sy      = oy + jitter(64);
            now_ms += $urandom_range(30);
            push_event(tgr_pkg::MODE_DOWN, s_id, ox + jitter(64), sy, now_ms, 1'b1, 1'b1);
            s_down  = 1'b1;
         end else if ($urandom_range(99) < 25) begin
            // tick early, around the deadline, or well after it
            case ($urandom_range(2))
               0: begin
                  now_ms += $urandom_range(40);
                  tick_t  = now_ms;
               end
               1: tick_t = press_ms + 32'(hold_eff) - 32'($urandom_range(1));
               default: begin
                  now_ms += $urandom_range(2 * hold_eff);
                  tick_t  = now_ms;
               end
            endcase
            push_event(tgr_pkg::MODE_TICK, 16'($urandom), $urandom, $urandom, tick_t,
                       1'($urandom_range(1)), 1'($urandom_range(1)));
         end else begin
            now_ms += $urandom_range(30);
            if (s_down && $urandom_range(1))
               push_event(tgr_pkg::MODE_MOTION, s_id, ox + jitter(amp), sy + jitter(amp),
                          now_ms, 1'b1, 1'b1);
            else
               push_event(tgr_pkg::MODE_MOTION, p_id, ox + jitter(amp), oy + jitter(amp),
                          now_ms, 1'b1, roll);
         end
      end
      // finish: cancel, leave it open, or lift the fingers in either order
      now_ms += $urandom_range(30);
      case ($urandom_range(9))
         0: push_event(tgr_pkg::MODE_CANCEL, p_id, 0, 0, now_ms, 1'b0, 1'b0);
         1: ;
         default: begin
            if (s_down && $urandom_range(1)) begin
               push_event(tgr_pkg::MODE_UP, s_id, $urandom, $urandom, now_ms, 1'b1, 1'b1);
               push_event(tgr_pkg::MODE_UP, p_id, $urandom, $urandom, now_ms + 32'd3,
                          1'b1, 1'b1);
            end else begin
               push_event(tgr_pkg::MODE_UP, p_id, $urandom, $urandom, now_ms, 1'b1, roll);
               if (s_down)
                  push_event(tgr_pkg::MODE_UP, s_id, $urandom, $urandom, now_ms + 32'd3,
                             1'b1, 1'b1);
            end
         end
      endcase
   endtask

   // Any event at all, with an occasional jump to the stale boundary
   task automatic noise_item();
      logic [31:0] t;
      case ($urandom_range(3))
         0: t = $urandom;
         1: begin
            now_ms += 32'(stale_eff) - 32'($urandom_range(1)) + 32'($urandom_range(2));
            t = now_ms;
         end
         default: begin
            now_ms += $urandom_range(40);
            t = now_ms;
         end
      endcase
      push_event(3'($urandom_range(7)),
                 $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom),
                 $urandom, $urandom, t, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic random_phase(input int budget);
      int stop_at;
      stop_at = sent_items + budget;
      while (sent_items < stop_at) begin
         if ($urandom_range(99) < 78) gesture_run();
         else noise_item();
      end
   endtask

   // Reset, directed events, then random phases under several register settings
   initial begin : stimulus
      int k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      directed_run();
      now_ms = 32'hFFFF_0000;
      configure(16'd500, 16'd128, 16'd640, 16'd5000);
      random_phase(PHASE_ITEMS);
      configure(16'd1, 16'd0, 16'd1, 16'd1);
      random_phase(PHASE_ITEMS);
      quiet_phase = 1'b1;
      configure(16'd0, 16'd0, 16'd0, 16'd0);
      random_phase(PHASE_ITEMS);
      quiet_phase = 1'b0;
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(PHASE_ITEMS);
      for (k = 0; k < 2; k++) begin
         configure(16'($urandom_range(3000, 1)), 16'($urandom_range(600)),
                   16'($urandom_range(4000, 1)), 16'($urandom_range(20000, 50)));
         random_phase(PHASE_ITEMS);
      end
      // drain and let the pipeline run empty
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (book.mismatches == 0 && book.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
